[rtl/pid_controller_integral_clamp_unit_assert.svh]
// Assertion macros for the PID controller with integral clamp.
`ifndef PID_CONTROLLER_INTEGRAL_CLAMP_UNIT_ASSERT_SVH
`define PID_CONTROLLER_INTEGRAL_CLAMP_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define PCIC_ASSERT_IMPL(lbl, clk_s, rstn_s, pre, post) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (pre) |-> (post)) \
    else $error("assertion failed");

`define PCIC_ASSERT_NEXT(lbl, clk_s, rstn_s, pre, post) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (pre) |=> (post)) \
    else $error("assertion failed");

`else

`define PCIC_ASSERT_IMPL(lbl, clk_s, rstn_s, pre, post)

`define PCIC_ASSERT_NEXT(lbl, clk_s, rstn_s, pre, post)

`endif

`endif

[rtl/pcic_pkg.sv]
// Shared widths, register indexes and constants of the PID controller.
`default_nettype none

package pcic_pkg;

  localparam int IN_W      = 16;
  localparam int ERR_W     = IN_W + 1;
  localparam int DELTA_W   = ERR_W + 1;
  localparam int GAIN_W    = 16;
  localparam int LIMIT_W   = 23;
  localparam int ACC_W     = 32;
  localparam int DRIVE_W   = 32;
  localparam int FRAC_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = LIMIT_W;

  // Products and sums of the drive path.
  localparam int PD_W  = GAIN_W + DELTA_W + 2;
  localparam int I_W   = GAIN_W + 1 + ACC_W;
  localparam int SUM_W = I_W + 1;
  localparam int Q_W   = SUM_W - 2 * FRAC_W;

  // Integral increment: magnitude of error * 256 divided by a constant.
  localparam int INTEGRAL_DIVISOR = 20;
  localparam int DIV_IN_W    = ERR_W + FRAC_W;
  localparam int DIV_SHIFT   = DIV_IN_W + $clog2(INTEGRAL_DIVISOR);
  localparam int DIV_MAGIC_W = DIV_IN_W + 1;
  localparam int DIV_PROD_W  = DIV_IN_W + DIV_MAGIC_W;
  localparam logic [DIV_MAGIC_W-1:0] DIV_MAGIC =
    DIV_MAGIC_W'(((64'd1 << DIV_SHIFT) + 64'(INTEGRAL_DIVISOR) - 64'd1) /
                 64'(INTEGRAL_DIVISOR));
  localparam int UPD_W = ACC_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd3;

  localparam logic [GAIN_W-1:0]  GAIN_P_RST = 16'd256;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST = 16'd0;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST = 16'd0;
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 23'h7FFFFF;

  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic signed [ACC_W-1:0] acc_t;

endpackage

`default_nettype wire

[rtl/pid_controller_integral_clamp_unit.sv]
// Top level of the positional PID controller with clamped integral.
//
// Channel | Direction | Payload (lowest bits first)
// in_     | slave     | tdata: setpoint[15:0], measured[31:16]
// out_    | master    | tdata: drive[31:0]
// cfg_    | write     | index 0 gain_p, 1 gain_i, 2 gain_d, 3 integral_limit
//
// Each transfer is captured in an input register, and its drive then lands in the output
// register; one item is taken per cycle while the output is not stalled.
// The combinational update of the error history and the integral sets that rate.
// A stalled output holds the input register, which then holds in_tready low.
// Synchronous reset clears the gains to their defaults, the history and the integral.
`default_nettype none

`include "pid_controller_integral_clamp_unit_assert.svh"

module pid_controller_integral_clamp_unit
  import pcic_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [2*IN_W-1:0]     in_tdata,   // setpoint[15:0], measured[31:16]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [DRIVE_W-1:0]         out_tdata,  // drive[31:0]
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [GAIN_W-1:0]  gain_p_r, gain_i_r, gain_d_r;
  logic [LIMIT_W-1:0] limit_r;

  logic               s1_valid_r;
  logic signed [IN_W-1:0] setpoint_r, measured_r;
  logic               out_valid_r;
  logic [DRIVE_W-1:0] drive_r;

  err_t               prev_err_r;
  acc_t               integ_r;

  logic               adv_w;
  err_t               err_w;
  logic signed [DELTA_W-1:0] delta_w;
  logic signed [PD_W-1:0]    term_p_w, term_d_w, pd_w;
  logic signed [I_W-1:0]     term_i_w;
  logic signed [SUM_W-1:0]   sum_w;
  logic                      rnd_w;
  logic signed [Q_W-1:0]     q_w;
  logic [DRIVE_W-1:0]        drive_nxt;

  logic [ERR_W-1:0]      err_mag_w;
  logic [DIV_IN_W-1:0]   div_in_w;
  logic [DIV_PROD_W-1:0] div_prod_w;
  logic [DIV_IN_W-1:0]   quot_w;
  logic signed [UPD_W-1:0] quot_s_w, inc_w, acc_sum_w, bound_w, acc_clamp_w;
  acc_t                  integ_nxt;

  assign adv_w      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || adv_w;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = drive_r;

  // Drive path.
  always_comb begin
    err_w    = ERR_W'(setpoint_r) - ERR_W'(measured_r);
    delta_w  = DELTA_W'(err_w) - DELTA_W'(prev_err_r);
    term_p_w = PD_W'($signed({1'b0, gain_p_r})) * PD_W'(err_w);
    term_d_w = PD_W'($signed({1'b0, gain_d_r})) * PD_W'(delta_w);
    pd_w     = term_p_w + term_d_w;
    term_i_w = I_W'($signed({1'b0, gain_i_r})) * I_W'(integ_r);
    sum_w    = (SUM_W'(pd_w) <<< FRAC_W) + SUM_W'(term_i_w);
    rnd_w    = sum_w[SUM_W-1] && (|sum_w[2*FRAC_W-1:0]);
    q_w      = Q_W'(sum_w >>> (2 * FRAC_W)) + $signed({{(Q_W-1){1'b0}}, rnd_w});
    if (q_w[Q_W-1:DRIVE_W-1] != {(Q_W-DRIVE_W+1){q_w[Q_W-1]}}) begin
      drive_nxt = q_w[Q_W-1] ? {1'b1, {(DRIVE_W-1){1'b0}}} : {1'b0, {(DRIVE_W-1){1'b1}}};
    end else begin
      drive_nxt = q_w[DRIVE_W-1:0];
    end
  end

  // Integral update with a reciprocal multiply for the constant division.
  always_comb begin
    err_mag_w  = err_w[ERR_W-1] ? ERR_W'(-err_w) : ERR_W'(err_w);
    div_in_w   = {err_mag_w, {FRAC_W{1'b0}}};
    div_prod_w = DIV_PROD_W'(div_in_w) * DIV_PROD_W'(DIV_MAGIC);
    quot_w     = DIV_IN_W'(div_prod_w >> DIV_SHIFT);
    quot_s_w   = $signed(UPD_W'(quot_w));
    inc_w      = err_w[ERR_W-1] ? -quot_s_w : quot_s_w;
    acc_sum_w  = UPD_W'(integ_r) + inc_w;
    bound_w    = $signed(UPD_W'({limit_r, {FRAC_W{1'b0}}}));
    if (acc_sum_w > bound_w) begin
      acc_clamp_w = bound_w;
    end else if (acc_sum_w < -bound_w) begin
      acc_clamp_w = -bound_w;
    end else begin
      acc_clamp_w = acc_sum_w;
    end
    integ_nxt = ACC_W'(acc_clamp_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r    <= GAIN_P_RST;
      gain_i_r    <= GAIN_I_RST;
      gain_d_r    <= GAIN_D_RST;
      limit_r     <= LIMIT_RST;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prev_err_r  <= '0;
      integ_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN_P: gain_p_r <= cfg_wdata[GAIN_W-1:0];
          REG_GAIN_I: gain_i_r <= cfg_wdata[GAIN_W-1:0];
          REG_GAIN_D: gain_d_r <= cfg_wdata[GAIN_W-1:0];
          REG_LIMIT:  limit_r  <= cfg_wdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (adv_w) begin
        out_valid_r <= 1'b1;
        prev_err_r  <= err_w;
        integ_r     <= integ_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      setpoint_r <= in_tdata[IN_W-1:0];
      measured_r <= in_tdata[2*IN_W-1:IN_W];
    end
    if (adv_w) begin
      drive_r <= drive_nxt;
    end
  end

  `PCIC_ASSERT_NEXT(a_stall_holds_state, clk, rst_n, s1_valid_r && out_valid_r && !out_tready, $stable(integ_r) && $stable(prev_err_r))
  `PCIC_ASSERT_IMPL(a_backpressure_only_when_full, clk, rst_n, !in_tready, s1_valid_r && out_valid_r)
  `PCIC_ASSERT_NEXT(a_advance_gives_result, clk, rst_n, adv_w, out_valid_r)
  `PCIC_ASSERT_NEXT(a_history_follows, clk, rst_n, adv_w, prev_err_r == $past(err_w))

endmodule

`default_nettype wire
